// ----- rtl/pdsv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pdsv_pkg;

  // Plant and number format constants
  localparam int COUNTS_PER_REV = 4000;
  localparam int COEF_FRAC_BITS = 16;
  localparam int ANGLE_FRAC     = 24;
  localparam int DRIVE_FRAC     = 16;
  localparam int DRV_ALIGN      = ANGLE_FRAC - DRIVE_FRAC;
  localparam int SUM_SHIFT      = DRV_ALIGN + COEF_FRAC_BITS;

  // Field widths
  localparam int DEG_W   = 9;
  localparam int CNT_W   = 12;
  localparam int COEF_W  = 32;
  localparam int LIM_W   = 23;
  localparam int DB_W    = 7;
  localparam int DRV_W   = 24;
  localparam int ERR_W   = 30;
  localparam int ANG_W   = 28;
  localparam int PCT_W   = 7;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int DIVD_W  = 40;
  localparam int DVSR_W  = LIM_W;
  localparam int DIV_BITS_PER_STEP = 2;
  localparam int DIV_STEPS = DIVD_W / DIV_BITS_PER_STEP;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Arithmetic constants
  localparam logic signed [MUL_W-1:0] K_TWO_PI_Q24 = 32'sd105414357;
  localparam logic signed [MUL_W-1:0] K_DEG_PER_REV = 32'sd360;
  localparam logic signed [MUL_W-1:0] K_PCT_FULL = 32'sd100;
  localparam logic [DVSR_W-1:0] DVSR_DEG = DVSR_W'(360);
  localparam logic [DVSR_W-1:0] DVSR_CPR = DVSR_W'(COUNTS_PER_REV);
  localparam logic [PCT_W-1:0]  PCT_MAX  = PCT_W'(100);
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (SUM_SHIFT - 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_PREV_DRIVE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ERROR_NOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ERROR_PREV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_PERCENT = 3'd4;

  localparam logic [COEF_W-1:0] RST_COEF_PREV_DRIVE = 32'd55993;
  localparam logic [COEF_W-1:0] RST_COEF_ERROR_NOW  = 32'd2171208;
  localparam logic [COEF_W-1:0] RST_COEF_ERROR_PREV = 32'hFFDF_7333; // -2133197
  localparam logic [LIM_W-1:0]  RST_SUPPLY_LIMIT    = 23'd1572864;
  localparam logic [DB_W-1:0]   RST_DEADBAND        = 7'd5;

  // Micro-operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
  localparam logic [OP_W-1:0] OP_MUL_REF   = 5'd1;
  localparam logic [OP_W-1:0] OP_DIV_REF   = 5'd2;
  localparam logic [OP_W-1:0] OP_WAIT_REF  = 5'd3;
  localparam logic [OP_W-1:0] OP_MUL_MEAS  = 5'd4;
  localparam logic [OP_W-1:0] OP_DIV_CPR   = 5'd5;
  localparam logic [OP_W-1:0] OP_WAIT_MEAS = 5'd6;
  localparam logic [OP_W-1:0] OP_MUL_DEG   = 5'd7;
  localparam logic [OP_W-1:0] OP_WAIT_MDEG = 5'd8;
  localparam logic [OP_W-1:0] OP_MUL_KD    = 5'd9;
  localparam logic [OP_W-1:0] OP_MUL_KE    = 5'd10;
  localparam logic [OP_W-1:0] OP_MUL_KL    = 5'd11;
  localparam logic [OP_W-1:0] OP_ACC       = 5'd12;
  localparam logic [OP_W-1:0] OP_SAT       = 5'd13;
  localparam logic [OP_W-1:0] OP_ZERO_MAG  = 5'd14;
  localparam logic [OP_W-1:0] OP_MUL_MAG   = 5'd15;
  localparam logic [OP_W-1:0] OP_DIV_MAG   = 5'd16;
  localparam logic [OP_W-1:0] OP_WAIT_MAG  = 5'd17;
  localparam logic [OP_W-1:0] OP_DONE      = 5'd18;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] STEP_DONE = 5'd18;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            wait_div;
    logic            wait_out;
    logic            jmp_lim_zero;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic            load;
    logic [OP_W-1:0] op;
  } ctrl_t;

  typedef struct packed {
    logic div_busy;
    logic lim_zero;
  } stat_t;

  typedef struct packed {
    logic [COEF_W-1:0] coef_prev_drive;
    logic [COEF_W-1:0] coef_error_now;
    logic [COEF_W-1:0] coef_error_prev;
    logic [LIM_W-1:0]  supply_limit;
    logic [DB_W-1:0]   deadband_percent;
  } cfg_t;

  typedef struct packed {
    logic [DRV_W-1:0] drive_volts;
    logic [PCT_W-1:0] high_duty;
    logic [PCT_W-1:0] low_duty;
    logic             high_enable;
    logic             low_enable;
    logic [DEG_W-1:0] measured_deg;
  } res_t;

  // Control store: one word per step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{OP_NOP, 1'b0, 1'b0, 1'b0, '0};
    case (pc)
      5'd0:  w = '{OP_MUL_REF,   1'b0, 1'b0, 1'b0, '0};
      5'd1:  w = '{OP_DIV_REF,   1'b0, 1'b0, 1'b0, '0};
      5'd2:  w = '{OP_WAIT_REF,  1'b1, 1'b0, 1'b0, '0};
      5'd3:  w = '{OP_MUL_MEAS,  1'b0, 1'b0, 1'b0, '0};
      5'd4:  w = '{OP_DIV_CPR,   1'b0, 1'b0, 1'b0, '0};
      5'd5:  w = '{OP_WAIT_MEAS, 1'b1, 1'b0, 1'b0, '0};
      5'd6:  w = '{OP_MUL_DEG,   1'b0, 1'b0, 1'b0, '0};
      5'd7:  w = '{OP_DIV_CPR,   1'b0, 1'b0, 1'b0, '0};
      5'd8:  w = '{OP_WAIT_MDEG, 1'b1, 1'b0, 1'b0, '0};
      5'd9:  w = '{OP_MUL_KD,    1'b0, 1'b0, 1'b0, '0};
      5'd10: w = '{OP_MUL_KE,    1'b0, 1'b0, 1'b0, '0};
      5'd11: w = '{OP_MUL_KL,    1'b0, 1'b0, 1'b0, '0};
      5'd12: w = '{OP_ACC,       1'b0, 1'b0, 1'b0, '0};
      5'd13: w = '{OP_SAT,       1'b0, 1'b0, 1'b0, '0};
      5'd14: w = '{OP_ZERO_MAG,  1'b0, 1'b0, 1'b1, STEP_DONE};
      5'd15: w = '{OP_MUL_MAG,   1'b0, 1'b0, 1'b0, '0};
      5'd16: w = '{OP_DIV_MAG,   1'b0, 1'b0, 1'b0, '0};
      5'd17: w = '{OP_WAIT_MAG,  1'b1, 1'b0, 1'b0, '0};
      5'd18: w = '{OP_DONE,      1'b0, 1'b1, 1'b0, '0};
      default: w = '{OP_DONE,    1'b0, 1'b1, 1'b0, '0};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pdsv_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface pdsv_in_if;
  logic                         valid;
  logic                         ready;
  logic [pdsv_pkg::DEG_W-1:0]   ref_deg;
  logic [pdsv_pkg::CNT_W-1:0]   encoder_count;

  modport source (output valid, output ref_deg, output encoder_count, input ready);
  modport sink   (input valid, input ref_deg, input encoder_count, output ready);
endinterface

interface pdsv_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pdsv_pkg::DRV_W-1:0] drive_volts;
  logic [pdsv_pkg::PCT_W-1:0]        high_duty;
  logic [pdsv_pkg::PCT_W-1:0]        low_duty;
  logic                              high_enable;
  logic                              low_enable;
  logic [pdsv_pkg::DEG_W-1:0]        measured_deg;

  modport source (output valid, output drive_volts, output high_duty, output low_duty,
                  output high_enable, output low_enable, output measured_deg, input ready);
  modport sink   (input valid, input drive_volts, input high_duty, input low_duty,
                  input high_enable, input low_enable, input measured_deg, output ready);
endinterface
`default_nettype wire

// ----- rtl/pdsv_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pdsv_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [pdsv_pkg::DIVD_W-1:0]   dividend,
  input  wire logic [pdsv_pkg::DVSR_W-1:0]   divisor,
  output logic                               busy,
  output logic [pdsv_pkg::DIVD_W-1:0]        quotient
);

  logic                              busy_r, busy_nxt;
  logic [pdsv_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [pdsv_pkg::DIVD_W-1:0]       quo_r, quo_nxt;
  logic [pdsv_pkg::DVSR_W-1:0]       rem_r, rem_nxt;
  logic [pdsv_pkg::DVSR_W-1:0]       dsr_r, dsr_nxt;
  logic [pdsv_pkg::DIVD_W-1:0]       quo_step;
  logic [pdsv_pkg::DVSR_W-1:0]       rem_step;
  logic [pdsv_pkg::DVSR_W:0]         trial;

  // Restoring division, DIV_BITS_PER_STEP quotient bits per cycle
  always_comb begin
    quo_step = quo_r;
    rem_step = rem_r;
    trial    = '0;
    for (int i = 0; i < pdsv_pkg::DIV_BITS_PER_STEP; i++) begin
      trial    = {rem_step, quo_step[pdsv_pkg::DIVD_W-1]};
      quo_step = {quo_step[pdsv_pkg::DIVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        trial       = trial - {1'b0, dsr_r};
        quo_step[0] = 1'b1;
      end
      rem_step = trial[pdsv_pkg::DVSR_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = quo_step;
      rem_nxt = rem_step;
      cnt_nxt = pdsv_pkg::DIV_CNT_W'(cnt_r + 1'b1);
      if (cnt_r == pdsv_pkg::DIV_CNT_W'(pdsv_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ----- rtl/pdsv_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pdsv_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire pdsv_pkg::ctrl_t              ctrl,
  input  wire pdsv_pkg::cfg_t               cfg,
  input  wire logic [pdsv_pkg::DEG_W-1:0]   ref_deg,
  input  wire logic [pdsv_pkg::CNT_W-1:0]   encoder_count,
  output pdsv_pkg::stat_t                   stat,
  output pdsv_pkg::res_t                    res
);

  localparam int AW = pdsv_pkg::ACC_W;
  localparam int MW = pdsv_pkg::MUL_W;

  logic [pdsv_pkg::DEG_W-1:0]        deg_r;
  logic [pdsv_pkg::CNT_W-1:0]        cnt_r;
  logic signed [pdsv_pkg::PROD_W-1:0] prod_r;
  logic signed [AW-1:0]              acc_r, acc_nxt;
  logic [pdsv_pkg::ANG_W-1:0]        ref_r;
  logic signed [pdsv_pkg::ERR_W-1:0] e_r;
  logic signed [pdsv_pkg::ERR_W-1:0] last_err_r;
  logic signed [pdsv_pkg::DRV_W-1:0] last_drv_r;
  logic signed [pdsv_pkg::DRV_W-1:0] u_r;
  logic [pdsv_pkg::PCT_W-1:0]        mag_r;
  logic [pdsv_pkg::DEG_W-1:0]        mdeg_r;

  logic signed [MW-1:0]              mul_a, mul_b;
  logic                              mul_en;
  logic signed [AW-1:0]              prod_ext;
  logic signed [AW-1:0]              u_full, lim_ext, u_sat;
  logic [pdsv_pkg::DRV_W-1:0]        u_abs;

  logic                              div_start;
  logic [pdsv_pkg::DIVD_W-1:0]       div_dividend;
  logic [pdsv_pkg::DVSR_W-1:0]       div_divisor;
  logic                              div_busy;
  logic [pdsv_pkg::DIVD_W-1:0]       div_quo;
  logic                              fwd, rev;

  pdsv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign u_abs = u_r[pdsv_pkg::DRV_W-1] ? pdsv_pkg::DRV_W'(-u_r) : pdsv_pkg::DRV_W'(u_r);

  // Multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (ctrl.op)
      pdsv_pkg::OP_MUL_REF: begin
        mul_a = pdsv_pkg::K_TWO_PI_Q24;
        mul_b = {{(MW - pdsv_pkg::DEG_W){1'b0}}, deg_r};
      end
      pdsv_pkg::OP_MUL_MEAS: begin
        mul_a = pdsv_pkg::K_TWO_PI_Q24;
        mul_b = {{(MW - pdsv_pkg::CNT_W){1'b0}}, cnt_r};
      end
      pdsv_pkg::OP_MUL_DEG: begin
        mul_a = pdsv_pkg::K_DEG_PER_REV;
        mul_b = {{(MW - pdsv_pkg::CNT_W){1'b0}}, cnt_r};
      end
      pdsv_pkg::OP_MUL_KD: begin
        mul_a = $signed(cfg.coef_prev_drive);
        mul_b = {{(MW - pdsv_pkg::DRV_W){last_drv_r[pdsv_pkg::DRV_W-1]}}, last_drv_r};
      end
      pdsv_pkg::OP_MUL_KE: begin
        mul_a = $signed(cfg.coef_error_now);
        mul_b = {{(MW - pdsv_pkg::ERR_W){e_r[pdsv_pkg::ERR_W-1]}}, e_r};
      end
      pdsv_pkg::OP_MUL_KL: begin
        mul_a = $signed(cfg.coef_error_prev);
        mul_b = {{(MW - pdsv_pkg::ERR_W){last_err_r[pdsv_pkg::ERR_W-1]}}, last_err_r};
      end
      pdsv_pkg::OP_MUL_MAG: begin
        mul_a = pdsv_pkg::K_PCT_FULL;
        mul_b = {{(MW - pdsv_pkg::DRV_W){1'b0}}, u_abs};
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Accumulator and saturation
  assign prod_ext = {{(AW - pdsv_pkg::PROD_W){prod_r[pdsv_pkg::PROD_W-1]}}, prod_r};
  assign u_full   = acc_r >>> pdsv_pkg::SUM_SHIFT;
  assign lim_ext  = $signed({{(AW - pdsv_pkg::LIM_W){1'b0}}, cfg.supply_limit});

  always_comb begin
    if (u_full > lim_ext) begin
      u_sat = lim_ext;
    end else if (u_full < -lim_ext) begin
      u_sat = -lim_ext;
    end else begin
      u_sat = u_full;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    case (ctrl.op)
      // last_drive product is Q.32; align it to the Q.40 error terms
      pdsv_pkg::OP_MUL_KE: acc_nxt = (prod_ext <<< pdsv_pkg::DRV_ALIGN) + pdsv_pkg::ROUND_BIAS;
      pdsv_pkg::OP_MUL_KL: acc_nxt = acc_r + prod_ext;
      pdsv_pkg::OP_ACC:    acc_nxt = acc_r + prod_ext;
      default:             acc_nxt = acc_r;
    endcase
  end

  // Divider launch
  always_comb begin
    div_start    = 1'b0;
    div_dividend = prod_r[pdsv_pkg::DIVD_W-1:0];
    div_divisor  = pdsv_pkg::DVSR_CPR;
    case (ctrl.op)
      pdsv_pkg::OP_DIV_REF: begin
        div_start   = 1'b1;
        div_divisor = pdsv_pkg::DVSR_DEG;
      end
      pdsv_pkg::OP_DIV_CPR: begin
        div_start   = 1'b1;
        div_divisor = pdsv_pkg::DVSR_CPR;
      end
      pdsv_pkg::OP_DIV_MAG: begin
        div_start   = 1'b1;
        div_divisor = cfg.supply_limit;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      deg_r <= ref_deg;
      cnt_r <= encoder_count;
    end
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    acc_r <= acc_nxt;
    case (ctrl.op)
      pdsv_pkg::OP_WAIT_REF:  ref_r  <= div_quo[pdsv_pkg::ANG_W-1:0];
      pdsv_pkg::OP_WAIT_MEAS: e_r    <= $signed({2'b00, ref_r} - {2'b00, div_quo[pdsv_pkg::ANG_W-1:0]});
      pdsv_pkg::OP_WAIT_MDEG: mdeg_r <= div_quo[pdsv_pkg::DEG_W-1:0];
      pdsv_pkg::OP_SAT:       u_r    <= u_sat[pdsv_pkg::DRV_W-1:0];
      pdsv_pkg::OP_ZERO_MAG:  mag_r  <= '0;
      pdsv_pkg::OP_WAIT_MAG: begin
        if (div_quo > pdsv_pkg::DIVD_W'(pdsv_pkg::PCT_MAX)) begin
          mag_r <= pdsv_pkg::PCT_MAX;
        end else begin
          mag_r <= div_quo[pdsv_pkg::PCT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Controller history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      last_drv_r <= '0;
    end else if (ctrl.op == pdsv_pkg::OP_SAT) begin
      last_err_r <= e_r;
      last_drv_r <= u_sat[pdsv_pkg::DRV_W-1:0];
    end
  end

  // Deadband and direction
  assign fwd = !u_r[pdsv_pkg::DRV_W-1] && (mag_r > cfg.deadband_percent);
  assign rev =  u_r[pdsv_pkg::DRV_W-1] && (mag_r > cfg.deadband_percent);

  assign res.drive_volts  = u_r;
  assign res.high_duty    = fwd ? mag_r : '0;
  assign res.low_duty     = rev ? mag_r : '0;
  assign res.high_enable  = fwd;
  assign res.low_enable   = rev;
  assign res.measured_deg = mdeg_r;

  assign stat.div_busy = div_busy;
  assign stat.lim_zero = (cfg.supply_limit == '0);

endmodule
`default_nettype wire

// ----- rtl/pdsv_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pdsv_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic            out_free,
  input  wire pdsv_pkg::stat_t stat,
  output pdsv_pkg::ctrl_t      ctrl,
  output logic                 busy
);

  logic                      busy_r, busy_nxt;
  logic [pdsv_pkg::PC_W-1:0] pc_r, pc_nxt;
  pdsv_pkg::ucode_t          word;
  logic                      hold;
  logic                      fire;

  assign word = pdsv_pkg::ucode_rom(pc_r);
  // Stall on the divider or on a full output register
  assign hold = (word.wait_div && stat.div_busy) || (word.wait_out && !out_free);
  assign fire = busy_r && !hold;

  assign ctrl.load = in_fire;
  assign ctrl.op   = fire ? word.op : pdsv_pkg::OP_NOP;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (fire) begin
      if (word.op == pdsv_pkg::OP_DONE) begin
        busy_nxt = 1'b0;
      end else if (word.jmp_lim_zero && stat.lim_zero) begin
        pc_nxt = word.target;
      end else begin
        pc_nxt = pdsv_pkg::PC_W'(pc_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

// ----- rtl/pd_servo_hbridge_drive_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// PD position servo with H-bridge output. Each transaction on in_ch is one control
// tick: the reference angle and encoder count become radians in Q.24, the Tustin PD
// recursion forms the drive in Q.16 volts, saturated to the supply limit, and the
// drive maps to a duty percent with a deadband choosing forward, reverse or off.
// A microcoded sequencer steps one 32x32 multiplier and one restoring divider
// (two quotient bits per cycle); the four divisions dominate the time from an item's
// acceptance to its result, and the last is skipped when the supply limit is zero.
// One item is in work at a time; the output register lets the next item be accepted
// while a result waits.
// Configuration writes are expected only while the block is idle.
module pd_servo_hbridge_drive_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  pdsv_in_if.sink                                in_ch,
  pdsv_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [pdsv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pdsv_pkg::COEF_W-1:0]       cfg_wdata
);

  pdsv_pkg::cfg_t  cfg_r, cfg_nxt;
  pdsv_pkg::ctrl_t ctrl;
  pdsv_pkg::stat_t stat;
  pdsv_pkg::res_t  res;
  pdsv_pkg::res_t  res_r;
  logic            out_valid_r, out_valid_nxt;
  logic            seq_busy;
  logic            in_fire;
  logic            out_free;

  assign in_fire  = in_ch.valid && !seq_busy;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !seq_busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pdsv_pkg::CFG_COEF_PREV_DRIVE:  cfg_nxt.coef_prev_drive  = cfg_wdata;
        pdsv_pkg::CFG_COEF_ERROR_NOW:   cfg_nxt.coef_error_now   = cfg_wdata;
        pdsv_pkg::CFG_COEF_ERROR_PREV:  cfg_nxt.coef_error_prev  = cfg_wdata;
        pdsv_pkg::CFG_SUPPLY_LIMIT:
          cfg_nxt.supply_limit = cfg_wdata[pdsv_pkg::LIM_W-1:0];
        pdsv_pkg::CFG_DEADBAND_PERCENT:
          cfg_nxt.deadband_percent = cfg_wdata[pdsv_pkg::DB_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_prev_drive  <= pdsv_pkg::RST_COEF_PREV_DRIVE;
      cfg_r.coef_error_now   <= pdsv_pkg::RST_COEF_ERROR_NOW;
      cfg_r.coef_error_prev  <= pdsv_pkg::RST_COEF_ERROR_PREV;
      cfg_r.supply_limit     <= pdsv_pkg::RST_SUPPLY_LIMIT;
      cfg_r.deadband_percent <= pdsv_pkg::RST_DEADBAND;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pdsv_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl),
    .busy     (seq_busy)
  );

  pdsv_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .cfg           (cfg_r),
    .ref_deg       (in_ch.ref_deg),
    .encoder_count (in_ch.encoder_count),
    .stat          (stat),
    .res           (res)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.op == pdsv_pkg::OP_DONE) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == pdsv_pkg::OP_DONE) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.drive_volts  = $signed(res_r.drive_volts);
  assign out_ch.high_duty    = res_r.high_duty;
  assign out_ch.low_duty     = res_r.low_duty;
  assign out_ch.high_enable  = res_r.high_enable;
  assign out_ch.low_enable   = res_r.low_enable;
  assign out_ch.measured_deg = res_r.measured_deg;

endmodule
`default_nettype wire

// ----- rtl/pdsv_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pdsv_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [pdsv_pkg::DRV_W-1:0] drive_volts,
  input wire logic [pdsv_pkg::PCT_W-1:0]        high_duty,
  input wire logic [pdsv_pkg::PCT_W-1:0]        low_duty,
  input wire logic                              high_enable,
  input wire logic                              low_enable
);

  // One transaction in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while previous transaction in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_enables_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(high_enable && low_enable))
    else $error("both bridge sides enabled");

  a_duty_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((high_enable || high_duty == '0) && (low_enable || low_duty == '0)))
    else $error("duty present on a disabled side");

  a_direction_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && high_enable) |-> (drive_volts > 0))
    else $error("forward drive with non-positive voltage");

endmodule

bind pd_servo_hbridge_drive_unit pdsv_chk u_pdsv_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .drive_volts (out_ch.drive_volts),
  .high_duty   (out_ch.high_duty),
  .low_duty    (out_ch.low_duty),
  .high_enable (out_ch.high_enable),
  .low_enable  (out_ch.low_enable)
);
`default_nettype wire
